// ===== src/assert_macros.svh =====
// Assertion macros used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, ignored while reset is held.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication in the next cycle, checked during reset as well.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/scc_pkg.sv =====
package scc_pkg;

    typedef enum logic [1:0] {
        CMD_DREAD  = 2'd0,
        CMD_DWRITE = 2'd1,
        CMD_IREAD  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    localparam logic [1:0] CFG_WRITE_BACK = 2'd0;
    localparam logic [1:0] CFG_ALLOCATE   = 2'd1;
    localparam logic [1:0] CFG_SPLIT      = 2'd2;

    typedef struct packed {
        logic write_back_mode;
        logic allocate_on_write;
        logic split_caches;
    } t_cfg;

    typedef struct packed {
        logic        hit;
        logic [1:0]  way;
        logic        fill_request;
        logic [31:0] fill_address;
        logic        writeback_request;
        logic [31:0] writeback_address;
        logic        memory_write;
        logic [31:0] memory_write_data;
    } t_result;

endpackage

// ===== src/scc_ram.sv =====
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ===== src/scc_front.sv =====
module scc_front #(
    parameter int SETS        = 64,
    parameter int BLOCK_BYTES = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  scc_pkg::t_cfg             i_cfg,
    input  logic                      i_clearing,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_cmd,
    input  logic [31:0]               i_address,
    input  logic [31:0]               i_write_data,
    input  logic                      i_pop,
    output logic                      o_q_valid,
    output scc_pkg::t_cmd             o_q_cmd,
    output logic [$clog2(SETS):0]     o_q_row,
    output logic [31-$clog2(BLOCK_BYTES)-$clog2(SETS):0] o_q_tag,
    output logic [31:0]               o_q_address,
    output logic [31:0]               o_q_data
);
    import scc_pkg::*;

    localparam int OB    = $clog2(BLOCK_BYTES);
    localparam int SB    = $clog2(SETS);
    localparam int TAG_W = 32 - OB - SB;
    localparam int ROW_W = SB + 1;

    t_cmd              r_cmd  [2];
    logic [ROW_W-1:0]  r_row  [2];
    logic [TAG_W-1:0]  r_tag  [2];
    logic [31:0]       r_addr [2];
    logic [31:0]       r_data [2];
    logic              r_wr_ptr, r_rd_ptr;
    logic [1:0]        r_count;

    logic              w_push;
    logic              w_half;
    logic [31:0]       w_set;
    logic [ROW_W-1:0]  w_row;

    assign o_ready = (r_count != 2'd2) && !i_clearing;
    assign w_push  = i_valid && o_ready;

    // Instruction reads go to the upper half of the tag store when split.
    assign w_half = (t_cmd'(i_cmd) == CMD_IREAD) && i_cfg.split_caches;
    assign w_set  = (i_address >> OB) & 32'(SETS - 1);
    assign w_row  = (ROW_W'(w_half) << SB) | ROW_W'(w_set);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_cmd[r_wr_ptr]  <= t_cmd'(i_cmd);
            r_row[r_wr_ptr]  <= w_row;
            r_tag[r_wr_ptr]  <= TAG_W'(i_address >> (OB + SB));
            r_addr[r_wr_ptr] <= i_address;
            r_data[r_wr_ptr] <= i_write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(w_push) - 2'(i_pop);
        end
    end

    assign o_q_valid   = r_count != 2'd0;
    assign o_q_cmd     = r_cmd[r_rd_ptr];
    assign o_q_row     = r_row[r_rd_ptr];
    assign o_q_tag     = r_tag[r_rd_ptr];
    assign o_q_address = r_addr[r_rd_ptr];
    assign o_q_data    = r_data[r_rd_ptr];
endmodule

// ===== src/scc_back.sv =====
module scc_back #(
    parameter int SETS        = 64,
    parameter int WAYS        = 4,
    parameter int BLOCK_BYTES = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  scc_pkg::t_cfg             i_cfg,
    input  logic                      i_q_valid,
    input  scc_pkg::t_cmd             i_q_cmd,
    input  logic [$clog2(SETS):0]     i_q_row,
    input  logic [31-$clog2(BLOCK_BYTES)-$clog2(SETS):0] i_q_tag,
    input  logic [31:0]               i_q_address,
    input  logic [31:0]               i_q_data,
    output logic                      o_pop,
    output logic                      o_clearing,
    output logic                      o_valid,
    input  logic                      i_ready,
    output scc_pkg::t_result          o_result
);
    import scc_pkg::*;

    localparam int OB    = $clog2(BLOCK_BYTES);
    localparam int SB    = $clog2(SETS);
    localparam int TAG_W = 32 - OB - SB;
    localparam int ROW_W = SB + 1;
    localparam int RK_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int E_W   = TAG_W + 2 + RK_W;
    localparam int RW    = WAYS * E_W;

    t_state           r_state, n_state;
    logic [ROW_W-1:0] r_clr_row;
    logic             r_out_valid;
    t_result          r_out;

    logic             w_re, w_we, w_load, w_out_free;
    logic [RW-1:0]    w_rdata, w_wdata, w_new_row, w_clr_data;
    logic [ROW_W-1:0] w_waddr;

    logic [TAG_W-1:0] w_tag   [WAYS];
    logic             w_vld   [WAYS];
    logic             w_drt   [WAYS];
    logic [RK_W-1:0]  w_rank  [WAYS];

    logic             w_acc, w_hit, w_around, w_alloc, w_inv_found, w_wr, w_mw;
    logic [RK_W-1:0]  w_hw, w_inv, w_lru, w_victim, w_uw, w_used_rank;
    logic             w_v_dirty;
    logic [TAG_W-1:0] w_v_tag;
    logic [31:0]      w_set;
    t_result          w_res;

    scc_ram #(.WIDTH(RW), .DEPTH(2 * SETS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (i_q_row),
        .o_rdata (w_rdata)
    );

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            w_rank[w] = w_rdata[w*E_W +: RK_W];
            w_drt[w]  = w_rdata[w*E_W + RK_W];
            w_vld[w]  = w_rdata[w*E_W + RK_W + 1];
            w_tag[w]  = w_rdata[w*E_W + RK_W + 2 +: TAG_W];
        end
    end

    // Lowest-numbered match wins, so the scan runs from the top way down.
    always_comb begin
        w_hit       = 1'b0;
        w_hw        = '0;
        w_inv_found = 1'b0;
        w_inv       = '0;
        w_lru       = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w_vld[w] && (w_tag[w] == i_q_tag)) begin
                w_hit = 1'b1;
                w_hw  = RK_W'(w);
            end
            if (!w_vld[w]) begin
                w_inv_found = 1'b1;
                w_inv       = RK_W'(w);
            end
            if (w_rank[w] == '0) begin
                w_lru = RK_W'(w);
            end
        end
    end

    assign w_acc      = i_q_cmd != CMD_NONE;
    assign w_victim   = w_inv_found ? w_inv : w_lru;
    assign w_around   = w_acc && !w_hit && (i_q_cmd == CMD_DWRITE)
                        && !i_cfg.allocate_on_write;
    assign w_alloc    = w_acc && !w_hit && !w_around;
    assign w_uw       = w_hit ? w_hw : w_victim;
    assign w_wr       = i_q_cmd == CMD_DWRITE;
    assign w_used_rank = w_rank[w_uw];
    assign w_v_dirty  = w_vld[w_victim] && w_drt[w_victim];
    assign w_v_tag    = w_tag[w_victim];
    assign w_set      = (i_q_address >> OB) & 32'(SETS - 1);
    assign w_mw       = w_wr && (w_around || !i_cfg.write_back_mode);

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            logic             sel;
            logic [TAG_W-1:0] t;
            logic             v, d;
            logic [RK_W-1:0]  r;
            sel = RK_W'(w) == w_uw;
            t   = w_tag[w];
            v   = w_vld[w];
            d   = w_drt[w];
            r   = w_rank[w];
            if (sel && w_alloc) begin
                t = i_q_tag;
                v = 1'b1;
                d = 1'b0;
            end
            if (sel && w_wr && i_cfg.write_back_mode) begin
                d = 1'b1;
            end
            if (sel) begin
                r = RK_W'(WAYS - 1);
            end else if (r > w_used_rank) begin
                r = r - 1'b1;
            end
            w_new_row[w*E_W +: E_W] = {t, v, d, r};
            w_clr_data[w*E_W +: E_W] = {TAG_W'(0), 1'b0, 1'b0, RK_W'(w)};
        end
    end

    always_comb begin
        w_res = '0;
        if (w_acc) begin
            w_res.hit = w_hit;
            w_res.way = w_hit ? 2'(w_hw) : (w_alloc ? 2'(w_victim) : 2'd0);
            w_res.fill_request = w_alloc;
            w_res.fill_address = w_alloc ? (i_q_address & ~32'(BLOCK_BYTES - 1)) : 32'd0;
            w_res.writeback_request = w_alloc && w_v_dirty;
            w_res.writeback_address = (w_alloc && w_v_dirty)
                ? ((32'(w_v_tag) << (OB + SB)) | (w_set << OB)) : 32'd0;
            w_res.memory_write      = w_mw;
            w_res.memory_write_data = w_mw ? i_q_data : 32'd0;
        end
    end

    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr_row == ROW_W'(2 * SETS - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (i_q_valid) n_state = ST_EXEC;
            ST_EXEC:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        w_re    = 1'b0;
        w_we    = 1'b0;
        w_load  = 1'b0;
        w_waddr = i_q_row;
        w_wdata = w_new_row;
        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_row;
                w_wdata = w_clr_data;
            end
            ST_IDLE: w_re = i_q_valid;
            ST_EXEC: begin
                w_load = w_out_free;
                w_we   = w_out_free && w_acc && !w_around;
            end
            default: ;
        endcase
    end

    assign o_pop      = w_load;
    assign o_clearing = r_state == ST_CLEAR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_row   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_row <= r_clr_row + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;
endmodule

// ===== src/set_assoc_cache_controller.sv =====
// Tag and policy controller for a set-associative LRU cache with a unified
// or split instruction/data organization. The back end reads the whole set
// (tags, valid, dirty and LRU ranks) from a single-port-write tag RAM in
// IDLE; in EXEC, once the result register is free, it resolves hit or
// victim, writes the updated set back (not on a write-around miss) and
// loads the result register. A two-word queue in front lets new words be
// taken while the back end works. After reset a clearing pass initializes
// all 2*SETS tag RAM rows, during which o_ready is low; configuration may
// be written at any idle time. SETS and BLOCK_BYTES must be powers of two.
module set_assoc_cache_controller #(
    parameter int SETS        = 64,
    parameter int WAYS        = 4,
    parameter int BLOCK_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_address,
    input  logic [31:0] i_write_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_hit,
    output logic [1:0]  o_way,
    output logic        o_fill_request,
    output logic [31:0] o_fill_address,
    output logic        o_writeback_request,
    output logic [31:0] o_writeback_address,
    output logic        o_memory_write,
    output logic [31:0] o_memory_write_data
);
    import scc_pkg::*;

    localparam int OB    = $clog2(BLOCK_BYTES);
    localparam int SB    = $clog2(SETS);
    localparam int TAG_W = 32 - OB - SB;
    localparam int ROW_W = SB + 1;

    t_cfg             r_cfg;
    logic             w_clearing, w_pop, w_q_valid;
    t_cmd             w_q_cmd;
    logic [ROW_W-1:0] w_q_row;
    logic [TAG_W-1:0] w_q_tag;
    logic [31:0]      w_q_address, w_q_data;
    t_result          w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{write_back_mode: 1'b1, allocate_on_write: 1'b1, split_caches: 1'b0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WRITE_BACK: r_cfg.write_back_mode   <= i_cfg_wdata;
                CFG_ALLOCATE:   r_cfg.allocate_on_write <= i_cfg_wdata;
                CFG_SPLIT:      r_cfg.split_caches      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    scc_front #(.SETS(SETS), .BLOCK_BYTES(BLOCK_BYTES)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_clearing   (w_clearing),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_pop        (w_pop),
        .o_q_valid    (w_q_valid),
        .o_q_cmd      (w_q_cmd),
        .o_q_row      (w_q_row),
        .o_q_tag      (w_q_tag),
        .o_q_address  (w_q_address),
        .o_q_data     (w_q_data)
    );

    scc_back #(.SETS(SETS), .WAYS(WAYS), .BLOCK_BYTES(BLOCK_BYTES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .i_q_row     (w_q_row),
        .i_q_tag     (w_q_tag),
        .i_q_address (w_q_address),
        .i_q_data    (w_q_data),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (w_res)
    );

    assign o_hit               = w_res.hit;
    assign o_way               = w_res.way;
    assign o_fill_request      = w_res.fill_request;
    assign o_fill_address      = w_res.fill_address;
    assign o_writeback_request = w_res.writeback_request;
    assign o_writeback_address = w_res.writeback_address;
    assign o_memory_write      = w_res.memory_write;
    assign o_memory_write_data = w_res.memory_write_data;
endmodule

// ===== src/scc_checker.sv =====
`include "assert_macros.svh"

module scc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_hit,
    input logic        o_fill_request,
    input logic [31:0] o_fill_address,
    input logic        o_writeback_request,
    input logic        o_memory_write,
    input logic [31:0] o_memory_write_data
);
    // A result word is never lost while the consumer stalls.
    `ASSERT_NEXT(a_out_hold, i_rst_n && o_valid && !i_ready, o_valid && $stable(o_fill_address))
    `ASSERT_NEXT(a_rst_clear, !i_rst_n, !o_valid && !o_ready)
    `ASSERT_SAME(a_hit_no_fill, o_valid && o_hit, !o_fill_request && !o_writeback_request)
    `ASSERT_SAME(a_wb_needs_fill, o_valid && o_writeback_request, o_fill_request)
    `ASSERT_SAME(a_unused_zero, o_valid && !o_memory_write && !o_fill_request,
                 o_memory_write_data == 32'd0 && o_fill_address == 32'd0)
endmodule

bind set_assoc_cache_controller scc_checker u_scc_checker (.*);
